// File: design/array_list_engine_defines.svh
// ----------------------------------------------------------------------------
// array_list_engine_defines.svh
// Assertion macros shared by the checker of the list engine. The macros
// expect signals named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Request and status codes plus the command and status bundles that join the
// list engine controller and datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam logic [2:0] REQ_CLEAR      = 3'd0;
  localparam logic [2:0] REQ_APPEND     = 3'd1;
  localparam logic [2:0] REQ_INSERT     = 3'd2;
  localparam logic [2:0] REQ_DELETE     = 3'd3;
  localparam logic [2:0] REQ_READ       = 3'd4;
  localparam logic [2:0] REQ_LOCATE     = 3'd5;
  localparam logic [2:0] REQ_APPEND_NEW = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] CNT_HOLD  = 2'd0;
  localparam logic [1:0] CNT_CLEAR = 2'd1;
  localparam logic [1:0] CNT_INC   = 2'd2;
  localparam logic [1:0] CNT_DEC   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;        // latch the incoming request
    logic       setup;       // preset the pointers for the latched request
    logic       rd_step;     // move the read pointer
    logic       wr_step;     // move the write pointer
    logic       step_down;   // pointers move down instead of up
    logic       we;          // write one entry
    logic       wa_count;    // write at the list tail instead of the write pointer
    logic       wd_value;    // write the request value instead of the read word
    logic [1:0] cnt_op;
    logic       cap_data;    // capture the read word as result data
    logic       cap_fidx;    // capture an index as the found index
    logic       fidx_count;  // that index is the list tail
    logic       finish;      // publish the result
    logic [1:0] res_status;
    logic       res_added;
  } ale_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       full;
    logic       cnt_zero;
    logic       match;       // word just read equals the request value
    logic       ins_last;    // write pointer sits just above the insert position
    logic       wr_last;     // write pointer is at the last entry
    logic       wr_last2;    // write pointer is at the entry before the last
  } ale_stat_t;

endpackage

// File: design/ale_dp.sv
// ----------------------------------------------------------------------------
// ale_dp
// Datapath of the list engine: request registers, entry memory, length and
// pointer registers, and the result registers.
// ----------------------------------------------------------------------------
module ale_dp #(
  parameter int CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  ale_pkg::ale_cmd_t   cmd,
  output ale_pkg::ale_stat_t  st,
  input  logic [2:0]          req_type,
  input  logic [7:0]          position,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic [1:0]          status,
  output logic signed [31:0]  data,
  output logic [6:0]          found_index,
  output logic                was_added,
  output logic [7:0]          list_length
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;

  logic [2:0]         req_type_q;
  logic [7:0]         position_q;
  logic signed [31:0] value_q;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      rd_ptr;
  logic [CW-1:0]      wr_ptr;
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  logic signed [31:0] data_q;
  logic signed [31:0] data_new;
  logic [CW-1:0]      fidx_q;
  logic [CW-1:0]      fidx_new;
  logic [IW-1:0]      wa;
  logic signed [31:0] wd;
  logic [PW:0]        pos_ext;
  logic [PW:0]        cnt_ext;
  logic [PW:0]        wr_ext;
  logic [CW+6:0]      fidx_ext;
  logic [CW+7:0]      len_ext;

  assign pos_ext = (PW + 1)'(position_q);
  assign cnt_ext = (PW + 1)'(count);
  assign wr_ext  = (PW + 1)'(wr_ptr);

  always_comb begin
    st.req_type   = req_type_q;
    st.pos_gt_cnt = pos_ext > cnt_ext;
    st.pos_ge_cnt = pos_ext >= cnt_ext;
    st.full       = count == CW'(CAPACITY);
    st.cnt_zero   = count == '0;
    st.match      = rdata == value_q;
    st.ins_last   = wr_ext == (pos_ext + (PW + 1)'(1));
    st.wr_last    = (wr_ptr + CW'(1)) == count;
    st.wr_last2   = (wr_ptr + CW'(2)) == count;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q <= req_type;
      position_q <= position;
      value_q    <= value;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      ale_pkg::CNT_CLEAR: count_next = '0;
      ale_pkg::CNT_INC:   count_next = count + CW'(1);
      ale_pkg::CNT_DEC:   count_next = count - CW'(1);
      default:            count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The insert shift walks both pointers down, every other walk goes up.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      case (req_type_q) inside
        ale_pkg::REQ_INSERT: begin
          rd_ptr <= count - CW'(1);
          wr_ptr <= count;
        end
        ale_pkg::REQ_DELETE, ale_pkg::REQ_READ: begin
          rd_ptr <= CW'(position_q);
          wr_ptr <= CW'(position_q);
        end
        default: begin
          rd_ptr <= '0;
          wr_ptr <= '0;
        end
      endcase
    end else begin
      if (cmd.rd_step) begin
        rd_ptr <= cmd.step_down ? rd_ptr - CW'(1) : rd_ptr + CW'(1);
      end
      if (cmd.wr_step) begin
        wr_ptr <= cmd.step_down ? wr_ptr - CW'(1) : wr_ptr + CW'(1);
      end
    end
  end

  assign wa = cmd.wa_count ? count[IW-1:0] : wr_ptr[IW-1:0];
  assign wd = cmd.wd_value ? value_q : rdata;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_ptr[IW-1:0]];
  end

  assign data_new = cmd.cap_data ? rdata : data_q;
  assign fidx_new = cmd.cap_fidx ? (cmd.fidx_count ? count : wr_ptr) : fidx_q;
  assign fidx_ext = {7'b0, fidx_new};
  assign len_ext  = {8'b0, count_next};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_q <= '0;
      fidx_q <= '0;
    end else begin
      data_q <= data_new;
      fidx_q <= fidx_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status      <= cmd.res_status;
      data        <= data_new;
      found_index <= fidx_ext[6:0];
      was_added   <= cmd.res_added;
      list_length <= len_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

// File: design/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Controller of the list engine: decodes a request and steps the datapath
// through the read, shift and scan sequences.
// ----------------------------------------------------------------------------
module ale_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ale_pkg::ale_stat_t st,
  output ale_pkg::ale_cmd_t  cmd,
  output logic               busy
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_INS_PRIME  = 4'd2;
  localparam logic [3:0] S_INS_SHIFT  = 4'd3;
  localparam logic [3:0] S_INS_PUT    = 4'd4;
  localparam logic [3:0] S_DEL_PRIME  = 4'd5;
  localparam logic [3:0] S_DEL_GRAB   = 4'd6;
  localparam logic [3:0] S_DEL_SHIFT  = 4'd7;
  localparam logic [3:0] S_RD_PRIME   = 4'd8;
  localparam logic [3:0] S_RD_GRAB    = 4'd9;
  localparam logic [3:0] S_SCAN_PRIME = 4'd10;
  localparam logic [3:0] S_SCAN       = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.cnt_op     = ale_pkg::CNT_HOLD;
    cmd.res_status = ale_pkg::ST_OK;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.setup = 1'b1;
        unique case (st.req_type)
          ale_pkg::REQ_CLEAR: begin
            cmd.cnt_op = ale_pkg::CNT_CLEAR;
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
          ale_pkg::REQ_APPEND: begin
            if (st.full) begin
              cmd.res_status = ale_pkg::ST_FULL;
            end else begin
              cmd.we       = 1'b1;
              cmd.wa_count = 1'b1;
              cmd.wd_value = 1'b1;
              cmd.cnt_op   = ale_pkg::CNT_INC;
            end
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
          ale_pkg::REQ_INSERT: begin
            if (st.pos_gt_cnt) begin
              cmd.res_status = ale_pkg::ST_BAD_POS;
              cmd.finish     = 1'b1;
              state_next     = S_IDLE;
            end else if (st.full) begin
              cmd.res_status = ale_pkg::ST_FULL;
              cmd.finish     = 1'b1;
              state_next     = S_IDLE;
            end else if (st.pos_ge_cnt) begin
              // Insert at the tail is a plain append.
              cmd.we       = 1'b1;
              cmd.wa_count = 1'b1;
              cmd.wd_value = 1'b1;
              cmd.cnt_op   = ale_pkg::CNT_INC;
              cmd.finish   = 1'b1;
              state_next   = S_IDLE;
            end else begin
              state_next = S_INS_PRIME;
            end
          end
          ale_pkg::REQ_DELETE: begin
            if (st.pos_ge_cnt) begin
              cmd.res_status = ale_pkg::ST_BAD_POS;
              cmd.finish     = 1'b1;
              state_next     = S_IDLE;
            end else begin
              state_next = S_DEL_PRIME;
            end
          end
          ale_pkg::REQ_READ: begin
            if (st.pos_ge_cnt) begin
              cmd.res_status = ale_pkg::ST_BAD_POS;
              cmd.finish     = 1'b1;
              state_next     = S_IDLE;
            end else begin
              state_next = S_RD_PRIME;
            end
          end
          ale_pkg::REQ_LOCATE: begin
            if (st.cnt_zero) begin
              cmd.res_status = ale_pkg::ST_NOT_FOUND;
              cmd.finish     = 1'b1;
              state_next     = S_IDLE;
            end else begin
              state_next = S_SCAN_PRIME;
            end
          end
          ale_pkg::REQ_APPEND_NEW: begin
            if (st.cnt_zero) begin
              cmd.we         = 1'b1;
              cmd.wa_count   = 1'b1;
              cmd.wd_value   = 1'b1;
              cmd.cnt_op     = ale_pkg::CNT_INC;
              cmd.cap_fidx   = 1'b1;
              cmd.fidx_count = 1'b1;
              cmd.res_added  = 1'b1;
              cmd.finish     = 1'b1;
              state_next     = S_IDLE;
            end else begin
              state_next = S_SCAN_PRIME;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_PRIME: begin
        cmd.rd_step   = 1'b1;
        cmd.step_down = 1'b1;
        state_next    = S_INS_SHIFT;
      end
      S_INS_SHIFT: begin
        cmd.we        = 1'b1;
        cmd.rd_step   = 1'b1;
        cmd.wr_step   = 1'b1;
        cmd.step_down = 1'b1;
        if (st.ins_last) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.we       = 1'b1;
        cmd.wd_value = 1'b1;
        cmd.cnt_op   = ale_pkg::CNT_INC;
        cmd.finish   = 1'b1;
        state_next   = S_IDLE;
      end
      S_DEL_PRIME: begin
        cmd.rd_step = 1'b1;
        state_next  = S_DEL_GRAB;
      end
      S_DEL_GRAB: begin
        cmd.cap_data = 1'b1;
        if (st.wr_last) begin
          cmd.cnt_op = ale_pkg::CNT_DEC;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_step = 1'b1;
          state_next  = S_DEL_SHIFT;
        end
      end
      S_DEL_SHIFT: begin
        cmd.we      = 1'b1;
        cmd.rd_step = 1'b1;
        cmd.wr_step = 1'b1;
        if (st.wr_last2) begin
          cmd.cnt_op = ale_pkg::CNT_DEC;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD_PRIME: begin
        state_next = S_RD_GRAB;
      end
      S_RD_GRAB: begin
        cmd.cap_data = 1'b1;
        cmd.finish   = 1'b1;
        state_next   = S_IDLE;
      end
      S_SCAN_PRIME: begin
        cmd.rd_step = 1'b1;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (st.match) begin
          cmd.cap_fidx = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end else if (st.wr_last) begin
          if (st.req_type == ale_pkg::REQ_LOCATE) begin
            cmd.res_status = ale_pkg::ST_NOT_FOUND;
          end else if (st.full) begin
            cmd.res_status = ale_pkg::ST_FULL;
          end else begin
            cmd.we         = 1'b1;
            cmd.wa_count   = 1'b1;
            cmd.wd_value   = 1'b1;
            cmd.cnt_op     = ale_pkg::CNT_INC;
            cmd.cap_fidx   = 1'b1;
            cmd.fidx_count = 1'b1;
            cmd.res_added  = 1'b1;
          end
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_step = 1'b1;
          cmd.wr_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Fixed-capacity contiguous list of signed 32-bit words with clear, append,
// insert, delete, read, locate and append-if-absent requests.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   --------  --------------------  ---------------------------------------
//   request   start & !busy         req_type, position, value
//   result    done (one cycle)      status, data, found_index, was_added,
//                                   list_length
//
// One request at a time. Clear, append, rejected and unused requests finish
// in the decode state; read passes through a prime and a grab state, and
// insert, delete, locate and append-if-absent walk the memory, moving one
// entry per cycle. The next request can be taken at the edge that takes the
// result. Synchronous reset empties the list but leaves the memory contents;
// done marks a result for one cycle and cannot be stalled.
module array_list_engine #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         req_type,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic [6:0]         found_index,
  output logic               was_added,
  output logic [7:0]         list_length
);

  // The controller only sees status flags and only issues commands; all
  // storage, including the entry memory, lives in the datapath.
  ale_pkg::ale_cmd_t  cmd;
  ale_pkg::ale_stat_t st;

  ale_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  ale_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .req_type    (req_type),
    .position    (position),
    .value       (value),
    .done        (done),
    .status      (status),
    .data        (data),
    .found_index (found_index),
    .was_added   (was_added),
    .list_length (list_length)
  );

endmodule

// File: design/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks of the list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "array_list_engine_defines.svh"

module ale_checker #(
  parameter int CAPACITY = 128
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic       was_added,
  input logic [7:0] list_length
);

  // An accepted request keeps the engine occupied in the next cycle.
  `ALE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not set busy")

  // The engine only goes idle by delivering a result.
  `ALE_ASSERT_NOW(a_idle_done, $fell(busy) && !$past(rst), done, "busy fell without result")

  // Two results never come back to back.
  `ALE_ASSERT_NEXT(a_done_gap, done, !done, "result strobe held two cycles")

  // A full rejection reports a list at capacity.
  `ALE_ASSERT_NOW(a_full_len, done && (status == ale_pkg::ST_FULL),
                  list_length == 8'(CAPACITY), "list full reported below capacity")

  // An added value leaves a non-empty list and an ok status.
  `ALE_ASSERT_NOW(a_added_ok, done && was_added,
                  (status == ale_pkg::ST_OK) && (list_length != 8'd0), "bad added result")

endmodule

bind array_list_engine ale_checker #(.CAPACITY(CAPACITY)) u_ale_checker (.*);

// File: tb/list_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_scoreboard_pkg
// Scoreboard for the list engine. It keeps its own copy of the list, works
// out the result of every accepted request and checks results in order.
// ----------------------------------------------------------------------------
package list_scoreboard_pkg;

  localparam int         LIST_CAPACITY = 128;
  localparam logic [2:0] REQ_UNUSED    = 3'd7;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [6:0]         found_index;
    logic               was_added;
    logic [7:0]         list_length;
  } list_result_t;

  class list_scoreboard;

    logic signed [31:0] words [LIST_CAPACITY];
    int unsigned        count;
    list_result_t       expected [$];
    int unsigned        errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function bit find_first(input logic signed [31:0] v, output int unsigned idx);
      idx = 0;
      for (int unsigned k = 0; k < count; k++) begin
        if (words[k] == v) begin
          idx = k;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Applies one accepted request to the list copy and queues its result.
    function void note_request(input logic [2:0] req, input logic [7:0] pos,
                               input logic signed [31:0] val);
      list_result_t res;
      int unsigned  hit;
      int unsigned  k;
      res        = '0;
      res.status = ale_pkg::ST_OK;
      case (req)
        ale_pkg::REQ_CLEAR: begin
          count = 0;
        end
        ale_pkg::REQ_APPEND: begin
          if (count >= LIST_CAPACITY) begin
            res.status = ale_pkg::ST_FULL;
          end else begin
            words[count] = val;
            count++;
          end
        end
        ale_pkg::REQ_INSERT: begin
          // The position is checked before the fill level.
          if (pos > count) begin
            res.status = ale_pkg::ST_BAD_POS;
          end else if (count >= LIST_CAPACITY) begin
            res.status = ale_pkg::ST_FULL;
          end else begin
            for (k = count; k > pos; k--) words[k] = words[k - 1];
            words[pos] = val;
            count++;
          end
        end
        ale_pkg::REQ_DELETE: begin
          if (pos >= count) begin
            res.status = ale_pkg::ST_BAD_POS;
          end else begin
            res.data = words[pos];
            for (k = pos; k + 1 < count; k++) words[k] = words[k + 1];
            count--;
          end
        end
        ale_pkg::REQ_READ: begin
          if (pos >= count) res.status = ale_pkg::ST_BAD_POS;
          else              res.data   = words[pos];
        end
        ale_pkg::REQ_LOCATE: begin
          if (find_first(val, hit)) res.found_index = hit[6:0];
          else                      res.status      = ale_pkg::ST_NOT_FOUND;
        end
        ale_pkg::REQ_APPEND_NEW: begin
          if (find_first(val, hit)) begin
            res.found_index = hit[6:0];
          end else if (count >= LIST_CAPACITY) begin
            res.status = ale_pkg::ST_FULL;
          end else begin
            words[count]    = val;
            res.found_index = count[6:0];
            res.was_added   = 1'b1;
            count++;
          end
        end
        default: begin
        end
      endcase
      res.list_length = count[7:0];
      expected.push_back(res);
    endfunction

    function void compare_field(input string name, input longint want_v,
                                input longint got_v);
      if (want_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                 want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(input list_result_t got);
      list_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %p",
                 $time, got);
        errors++;
        return;
      end
      want = expected.pop_front();
      if ($isunknown(got)) begin
        $display("%0t: unknown bits in result, expected %p, actual %p", $time,
                 want, got);
        errors++;
        return;
      end
      compare_field("status", want.status, got.status);
      compare_field("data", $signed(want.data), $signed(got.data));
      compare_field("found_index", want.found_index, got.found_index);
      compare_field("was_added", want.was_added, got.was_added);
      compare_field("list_length", want.list_length, got.list_length);
    endfunction

  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the list engine. A directed opening covers the empty list,
// the word extremes, every request code and the bad-position and not-found
// rejections; random requests then grow the list to full and shrink it again
// while the sender idles at several rates. Every result is checked field by
// field against a scoreboard that keeps its own copy of the list.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam int                 ITEMS_PER_PHASE = 157;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         req_type = ale_pkg::REQ_CLEAR;
  logic [7:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [6:0]         found_index;
  logic               was_added;
  logic [7:0]         list_length;

  list_scoreboard_pkg::list_scoreboard sb = new();

  // Percentage of requests that are followed by an idle gap on the sender.
  int unsigned idle_pct = 0;
  // While set, the random mix favors requests that lengthen the list.
  bit growing = 1'b1;

  array_list_engine #(.CAPACITY(list_scoreboard_pkg::LIST_CAPACITY)) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .position    (position),
    .value       (value),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .data        (data),
    .found_index (found_index),
    .was_added   (was_added),
    .list_length (list_length)
  );

  always #6 clk = ~clk;

  // Results are taken at the rising edge that ends the cycle in which done is
  // high. The receiver has no way to stall them, so every strobe is checked.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(list_scoreboard_pkg::list_result_t'{status, data, found_index,
                                                          was_added, list_length});
    end
  end

  // Presents one request from the falling edge on and returns once it has
  // been accepted. Start stays high afterwards, so back-to-back requests keep
  // it asserted without a dip.
  task automatic send_request(input logic [2:0] r, input logic [7:0] p,
                              input logic signed [31:0] v);
    @(negedge clk);
    start    <= 1'b1;
    req_type <= r;
    position <= p;
    value    <= v;
    do @(posedge clk); while (busy);
    sb.note_request(r, p, v);
  endtask

  // Lowers start for a random gap. Most gaps are short; a few are long enough
  // to span a whole walk through the list, so the next request lands on
  // every phase of the engine's work.
  task automatic sender_gap();
    int unsigned cycles;
    if ($urandom_range(0, 99) < idle_pct) begin
      cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                           : $urandom_range(1, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  // Builds one random request. The mix swings between a growing phase that
  // fills the list up to capacity and a shrinking phase that drains it, so
  // that both the full list and the nearly empty list get exercised with
  // random contents. Positions mostly fall inside the list, values often
  // repeat words already stored so that searches hit.
  task automatic next_random(output logic [2:0] r, output logic [7:0] p,
                             output logic signed [31:0] v);
    int unsigned n;
    int unsigned roll;
    n = sb.count;
    if (n >= list_scoreboard_pkg::LIST_CAPACITY && $urandom_range(0, 11) == 0) begin
      growing = 1'b0;
    end
    if (n <= 2) growing = 1'b1;

    roll = $urandom_range(0, 99);
    if (growing) begin
      if      (roll < 30) r = ale_pkg::REQ_APPEND;
      else if (roll < 50) r = ale_pkg::REQ_INSERT;
      else if (roll < 65) r = ale_pkg::REQ_APPEND_NEW;
      else if (roll < 75) r = ale_pkg::REQ_DELETE;
      else if (roll < 83) r = ale_pkg::REQ_READ;
      else if (roll < 93) r = ale_pkg::REQ_LOCATE;
      else if (roll < 99) r = ale_pkg::REQ_READ;
      else                r = list_scoreboard_pkg::REQ_UNUSED;
    end else begin
      if      (roll < 40) r = ale_pkg::REQ_DELETE;
      else if (roll < 50) r = ale_pkg::REQ_INSERT;
      else if (roll < 58) r = ale_pkg::REQ_APPEND;
      else if (roll < 63) r = ale_pkg::REQ_APPEND_NEW;
      else if (roll < 75) r = ale_pkg::REQ_READ;
      else if (roll < 90) r = ale_pkg::REQ_LOCATE;
      else if (roll < 97) r = list_scoreboard_pkg::REQ_UNUSED;
      else                r = ale_pkg::REQ_CLEAR;
    end

    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      p = 8'($urandom_range(0, n));
    end else if (roll < 9) begin
      p = 8'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 3))
        0:       p = 8'd0;
        1:       p = (n > 0) ? 8'(n - 1) : 8'd0;
        2:       p = 8'(n);
        default: p = 8'(n + 1);
      endcase
    end

    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      v = $signed($urandom());
    end else if (roll < 7 && n > 0) begin
      v = sb.words[$urandom_range(0, n - 1)];
    end else if (roll < 9) begin
      v = $signed(32'($urandom_range(0, 15))) - 32'sd8;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = WORD_MIN;
        1:       v = WORD_MAX;
        2:       v = 32'sd0;
        default: v = -32'sd1;
      endcase
    end
  endtask

  initial begin : stimulus
    logic [2:0]         r;
    logic [7:0]         p;
    logic signed [31:0] v;

    // Synchronous reset, released on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening, back to back. The list goes through the contents
    // [min], [min, max], [0, min, max], [0, min, max, -1] and onward.
    send_request(ale_pkg::REQ_CLEAR,      8'd0,   32'sd0);
    send_request(ale_pkg::REQ_READ,       8'd0,   32'sd0);     // read of an empty list
    send_request(ale_pkg::REQ_DELETE,     8'd0,   32'sd0);     // delete from an empty list
    send_request(ale_pkg::REQ_LOCATE,     8'd0,   32'sd5);     // search with no entries
    send_request(ale_pkg::REQ_APPEND_NEW, 8'd0,   WORD_MIN);   // added at index zero
    send_request(ale_pkg::REQ_APPEND,     8'd0,   WORD_MAX);
    send_request(ale_pkg::REQ_INSERT,     8'd0,   32'sd0);     // shifts the whole list
    send_request(ale_pkg::REQ_INSERT,     8'd3,   -32'sd1);    // position equal to length
    send_request(ale_pkg::REQ_INSERT,     8'd5,   32'sd7);     // one past the length
    send_request(ale_pkg::REQ_INSERT,     8'd255, 32'sd7);     // far out of range
    send_request(ale_pkg::REQ_READ,       8'd3,   32'sd0);     // last entry
    send_request(ale_pkg::REQ_READ,       8'd4,   32'sd0);     // position equal to length
    send_request(ale_pkg::REQ_READ,       8'd128, 32'sd0);
    send_request(ale_pkg::REQ_LOCATE,     8'd0,   WORD_MAX);
    send_request(ale_pkg::REQ_LOCATE,     8'd0,   32'sd12345); // no match
    send_request(ale_pkg::REQ_APPEND_NEW, 8'd0,   32'sd0);     // already present
    send_request(ale_pkg::REQ_APPEND,     8'd0,   32'sd0);     // plain append, duplicate
    send_request(ale_pkg::REQ_LOCATE,     8'd0,   32'sd0);     // first of two matches
    send_request(ale_pkg::REQ_DELETE,     8'd1,   32'sd0);     // removes the minimum word
    send_request(ale_pkg::REQ_DELETE,     8'd3,   32'sd0);     // removes the tail
    send_request(list_scoreboard_pkg::REQ_UNUSED, 8'hff, -32'sd1); // unused request code
    send_request(ale_pkg::REQ_DELETE,     8'd200, 32'sd0);
    send_request(ale_pkg::REQ_CLEAR,      8'd0,   32'sd0);

    // Random phases with different sender idle rates. Between phases the
    // sender waits for all results, which also covers the drained case.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 64;
        2:       idle_pct = 18;
        default: idle_pct = 0;
      endcase
      repeat (ITEMS_PER_PHASE) begin
        next_random(r, p, v);
        send_request(r, p, v);
        sender_gap();
      end
      hold_until_drained();
    end

    // A settling margin after the last result catches any stray strobe.
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far below this.
  initial begin : watchdog
    #15ms;
    $display("timeout with %0d results outstanding", sb.expected.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/ale_pkg.sv
design/ale_dp.sv
design/ale_ctrl.sv
design/array_list_engine.sv
design/ale_checker.sv
tb/list_scoreboard_pkg.sv
tb/tb_top.sv
